// ===== rtl/core/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg
// shared types and constants of the range predecessor search block
// ----------------------------------------------------------------------------
package rps_pkg;

  // fixed widths of the request and result fields
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DATA_W = 32;

  // request kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TARGET,
    ST_SCAN,
    ST_LAST,
    ST_RESP
  } state_e;

  // controls from the sequencer to the compare unit
  typedef struct packed {
    logic clr;     // drop the running best
    logic tgt_ld;  // read data is the target
    logic cmp_en;  // read data is a range element
  } scan_ctrl_t;

endpackage

// ===== rtl/core/rps_ram.sv =====
// ----------------------------------------------------------------------------
// rps_ram
// single-port ram, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module rps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rps_scan.sv =====
// ----------------------------------------------------------------------------
// rps_scan
// compare unit: keeps the target and the running best over the range
// ----------------------------------------------------------------------------
module rps_scan
  import rps_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scan_ctrl_t             ctrl_i,
  input  logic [VALUE_WIDTH-1:0] rd_value_i,
  input  logic [IDX_W-1:0]       rd_idx_i,
  output logic                   have_o,
  output logic [IDX_W-1:0]       best_idx_o,
  output logic [VALUE_WIDTH-1:0] best_val_o
);

  logic                   have_q, have_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [VALUE_WIDTH-1:0] best_val_q, best_val_d;
  logic [VALUE_WIDTH-1:0] target_q, target_d;
  logic                   take;

  // not above target, and not below the best so far (rightmost on ties)
  assign take = (rd_value_i <= target_q) && (!have_q || (rd_value_i >= best_val_q));

  always_comb begin
    have_d     = have_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    target_d   = target_q;
    if (ctrl_i.clr) begin
      have_d     = 1'b0;
      best_idx_d = '0;
      best_val_d = '0;
    end else if (ctrl_i.tgt_ld) begin
      target_d = rd_value_i;
    end else if (ctrl_i.cmp_en && take) begin
      have_d     = 1'b1;
      best_idx_d = rd_idx_i;
      best_val_d = rd_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q     <= 1'b0;
      best_idx_q <= '0;
      best_val_q <= '0;
    end else begin
      have_q     <= have_d;
      best_idx_q <= best_idx_d;
      best_val_q <= best_val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
  end

  assign have_o     = have_q;
  assign best_idx_o = best_idx_q;
  assign best_val_o = best_val_q;

endmodule

// ===== rtl/core/range_predecessor_search.sv =====
// ----------------------------------------------------------------------------
// range_predecessor_search
// store of unsigned values with single-entry writes and range predecessor
// queries, one ram port and one shared compare unit under a sequencer
// ----------------------------------------------------------------------------
// order: a write gives its result in the cycle after the request is taken;
//   a query fetches the target, scans the range entries, waits for the last
//   read and then gives it; an error or empty range gives it the cycle after
// requests: one at a time, busy high through the result cycle
// reset: a clearing pass zeroes the store, one entry a cycle, with busy
//   high; results are strobed for one cycle, no stall
module range_predecessor_search
  import rps_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              mode_i,
  input  logic [IDX_W-1:0]  write_index_i,
  input  logic [DATA_W-1:0] write_value_i,
  input  logic [IDX_W-1:0]  range_start_i,
  input  logic [IDX_W-1:0]  range_end_i,
  output logic              done_o,
  output logic              found_o,
  output logic [IDX_W-1:0]  found_index_o,
  output logic [DATA_W-1:0] found_value_o,
  output logic              range_error_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  state_e state_q, state_d;

  // clearing pass pointer
  logic [AW-1:0] clr_ptr_q, clr_ptr_d;

  // query bound and scan pointer
  logic [IDX_W-1:0] hi_q, hi_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic             err_q, err_d;

  // what the ram returns this cycle (issued last cycle)
  logic             rd_tgt_q, rd_el_q;
  logic [IDX_W-1:0] rd_idx_q;

  // ram port
  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  scan_ctrl_t             ctrl;
  logic                   have;
  logic [IDX_W-1:0]       best_idx;
  logic [VALUE_WIDTH-1:0] best_val;

  logic                   accept;
  logic                   wr_in_store;
  logic                   no_target;
  logic [IDX_W:0]         hi_p1;

  assign accept = start && !busy;

  // index checks against the store depth, in 32-bit arithmetic
  assign wr_in_store = (32'(write_index_i) < 32'(STORE_DEPTH));
  assign no_target   = ((32'(range_end_i) + 32'd1) >= 32'(STORE_DEPTH));
  assign hi_p1       = {1'b0, hi_q} + {{IDX_W{1'b0}}, 1'b1};

  always_comb begin
    state_d   = state_q;
    clr_ptr_d = clr_ptr_q;
    hi_d      = hi_q;
    j_d       = j_q;
    err_d     = err_q;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    ctrl      = '{clr: 1'b0, tgt_ld: rd_tgt_q, cmp_en: rd_el_q};
    busy      = 1'b1;
    done_o    = 1'b0;

    unique case (state_q)
      // zero every entry after reset
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_ptr_q;
        clr_ptr_d = clr_ptr_q + {{(AW-1){1'b0}}, 1'b1};
        if (clr_ptr_q == AW'(STORE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          ctrl.clr = 1'b1;
          hi_d     = range_end_i;
          j_d      = range_start_i;
          err_d    = 1'b0;
          if (mode_i == MODE_WRITE) begin
            // write goes straight into the store if its index is in it, result is all zero
            ram_we    = wr_in_store;
            ram_addr  = AW'(write_index_i);
            ram_wdata = VALUE_WIDTH'(64'(write_value_i));
            state_d   = ST_RESP;
          end else if (no_target) begin
            err_d   = 1'b1;
            state_d = ST_RESP;
          end else if (range_start_i > range_end_i) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_TARGET;
          end
        end
      end

      // fetch the value just past the range
      ST_TARGET: begin
        ram_addr = AW'(hi_p1);
        state_d  = ST_SCAN;
      end

      // one range entry read per cycle, compared in the cycle after
      ST_SCAN: begin
        ram_addr = AW'(j_q);
        j_d      = j_q + {{(IDX_W-1){1'b0}}, 1'b1};
        if (j_q == hi_q) begin
          state_d = ST_LAST;
        end
      end

      // last entry comes back from the ram
      ST_LAST: begin
        state_d = ST_RESP;
      end

      ST_RESP: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_ptr_q <= '0;
      err_q     <= 1'b0;
      rd_tgt_q  <= 1'b0;
      rd_el_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_ptr_q <= clr_ptr_d;
      err_q     <= err_d;
      rd_tgt_q  <= (state_q == ST_TARGET);
      rd_el_q   <= (state_q == ST_SCAN);
    end
  end

  // bound and scan position carry no reset
  always_ff @(posedge clk_i) begin
    hi_q     <= hi_d;
    j_q      <= j_d;
    rd_idx_q <= j_q;
  end

  rps_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  rps_scan #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .rd_value_i (ram_rdata),
    .rd_idx_i   (rd_idx_q),
    .have_o     (have),
    .best_idx_o (best_idx),
    .best_val_o (best_val)
  );

  // result fields hold steady through the strobe cycle
  assign found_o       = have;
  assign found_index_o = best_idx;
  assign found_value_o = DATA_W'(64'(best_val));
  assign range_error_o = err_q;

endmodule
